[rtl/d2q9_bgk_collision_macros.svh]
// Assertion macros for the D2Q9 BGK collision block
`ifndef D2Q9_BGK_COLLISION_MACROS_SVH
`define D2Q9_BGK_COLLISION_MACROS_SVH

// implication checked outside reset
`define D2Q9_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked also during reset
`define D2Q9_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/d2q9_pkg.sv]
// Types, constants and saturation helpers for the D2Q9 BGK collision block
package d2q9_pkg;

    localparam int NDIR      = 9;
    localparam int WORD_W    = 32;
    localparam int WGT_W     = 25;
    localparam int RATE_W    = 26;
    localparam int DIV_STEPS = 31;
    localparam int NWGT      = 3;

    localparam logic [WGT_W-1:0]  WEIGHT_REST_RST = 25'd7456540;
    localparam logic [WGT_W-1:0]  WEIGHT_AXIS_RST = 25'd1864135;
    localparam logic [WGT_W-1:0]  WEIGHT_DIAG_RST = 25'd466034;
    localparam logic [RATE_W-1:0] RELAX_RATE_RST  = 26'd16777216;

    typedef enum logic [1:0] {
        REG_WEIGHT_REST = 2'd0,
        REG_WEIGHT_AXIS = 2'd1,
        REG_WEIGHT_DIAG = 2'd2,
        REG_RELAX_RATE  = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [NDIR-1:0][WORD_W-1:0] f;
        logic [WORD_W-1:0]           rho;
        logic                        pos;
        logic [1:0]                  neg;
        logic [1:0]                  ovf;
    } div_pay_t;

    typedef struct packed {
        logic [NDIR-1:0][WORD_W-1:0] f;
        logic [WORD_W-1:0]           rho;
        logic [WORD_W-1:0]           ux;
        logic [WORD_W-1:0]           uy;
    } cl_pay_t;

    function automatic logic signed [63:0] sx(input logic [WORD_W-1:0] v);
        return {{32{v[WORD_W-1]}}, v};
    endfunction

    function automatic logic [WORD_W-1:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'h7fff_ffff;
        end else if (v < -64'sd2147483648) begin
            return 32'h8000_0000;
        end
        return v[WORD_W-1:0];
    endfunction

endpackage

[rtl/d2q9_bgk_collision.sv]
// D2Q9 BGK collision of one lattice cell per word, fully pipelined
`include "d2q9_bgk_collision_macros.svh"
// Accepts one cell per clock unless stalled and returns its post-collision
// distributions, density and velocity; the 31-stage restoring divider that
// forms velocity is most of the pipeline. A stalled output freezes the whole
// pipeline, so s_tready follows m_tready while a word waits at the output.
module d2q9_bgk_collision
    import d2q9_pkg::*;
#(
    parameter int FRAC_BITS = 24
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [25:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // f_rest, f_east, f_north, f_west, f_south, f_northeast, f_northwest,
    // f_southwest, f_southeast
    input  logic [287:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // g_rest, g_east, g_north, g_west, g_south, g_northeast, g_northwest,
    // g_southwest, g_southeast, density, velocity_x, velocity_y
    output logic [383:0] m_tdata
);

    localparam int PRE_SH = 31 - FRAC_BITS;
    localparam int LAT    = DIV_STEPS + 11;
    localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;

    logic [WGT_W-1:0]  wgt_reg [0:NWGT-1];
    logic [RATE_W-1:0] omega_reg;
    logic [LAT-1:0]    vld_reg;
    logic              ce;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wgt_reg[0] <= WEIGHT_REST_RST;
            wgt_reg[1] <= WEIGHT_AXIS_RST;
            wgt_reg[2] <= WEIGHT_DIAG_RST;
            omega_reg  <= RELAX_RATE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_WEIGHT_REST: wgt_reg[0] <= cfg_wdata[WGT_W-1:0];
                REG_WEIGHT_AXIS: wgt_reg[1] <= cfg_wdata[WGT_W-1:0];
                REG_WEIGHT_DIAG: wgt_reg[2] <= cfg_wdata[WGT_W-1:0];
                REG_RELAX_RATE:  omega_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign ce       = !vld_reg[LAT-1] || m_tready;
    assign s_tready = ce;
    assign m_tvalid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    // sums
    logic signed [63:0] sum_s, jx_s, jy_s;
    logic [NDIR-1:0][WORD_W-1:0] fin;
    logic [NDIR-1:0][WORD_W-1:0] f1_reg;
    logic [WORD_W-1:0] rho1_reg, jx1_reg, jy1_reg;

    assign fin = s_tdata;

    always_comb begin
        sum_s = '0;
        for (int d = 0; d < NDIR; d++) begin
            sum_s = sum_s + sx(fin[d]);
        end
        jx_s = (sx(fin[1]) + sx(fin[5]) + sx(fin[8])) - (sx(fin[3]) + sx(fin[6]) + sx(fin[7]));
        jy_s = (sx(fin[2]) + sx(fin[5]) + sx(fin[6])) - (sx(fin[4]) + sx(fin[7]) + sx(fin[8]));
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            f1_reg   <= fin;
            rho1_reg <= sat32(sum_s);
            jx1_reg  <= sat32(jx_s);
            jy1_reg  <= sat32(jy_s);
        end
    end

    // divider setup
    div_pay_t          dpay_reg [0:DIV_STEPS];
    logic [1:0][31:0]  drem_reg [0:DIV_STEPS];
    logic [1:0][30:0]  dq_reg   [0:DIV_STEPS];
    logic [1:0][30:0]  dn_reg   [0:DIV_STEPS];
    div_pay_t          dpay_next;
    logic [1:0][31:0]  drem_next;
    logic [1:0][30:0]  dn_next;
    logic [1:0][31:0]  jsel, absj;
    logic [1:0][62:0]  wide;

    always_comb begin
        jsel[0] = jx1_reg;
        jsel[1] = jy1_reg;
        dpay_next.f   = f1_reg;
        dpay_next.rho = rho1_reg;
        dpay_next.pos = ($signed(rho1_reg) > 32'sd0);
        for (int a = 0; a < 2; a++) begin
            dpay_next.neg[a] = jsel[a][31];
            absj[a]          = jsel[a][31] ? (~jsel[a] + 32'd1) : jsel[a];
            drem_next[a]     = absj[a] >> PRE_SH;
            wide[a]          = {31'd0, absj[a]} << FRAC_BITS;
            dn_next[a]       = wide[a][30:0];
            dpay_next.ovf[a] = (drem_next[a] >= {1'b0, rho1_reg[30:0]});
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            dpay_reg[0] <= dpay_next;
            drem_reg[0] <= drem_next;
            dq_reg[0]   <= '0;
            dn_reg[0]   <= dn_next;
        end
    end

    for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
        logic [1:0][31:0] t;
        logic [1:0]       ge;
        always_comb begin
            for (int a = 0; a < 2; a++) begin
                t[a]  = {drem_reg[k-1][a][30:0], dn_reg[k-1][a][30]};
                ge[a] = (t[a] >= {1'b0, dpay_reg[k-1].rho[30:0]});
            end
        end
        always_ff @(posedge aclk) begin
            if (ce) begin
                dpay_reg[k] <= dpay_reg[k-1];
                for (int a = 0; a < 2; a++) begin
                    drem_reg[k][a] <= ge[a] ? (t[a] - {1'b0, dpay_reg[k-1].rho[30:0]}) : t[a];
                    dq_reg[k][a]   <= {dq_reg[k-1][a][29:0], ge[a]};
                    dn_reg[k][a]   <= {dn_reg[k-1][a][29:0], 1'b0};
                end
            end
        end
    end

    // velocity, equilibrium and relaxation stages
    cl_pay_t cl_reg [0:8];
    cl_pay_t cl_next;
    logic [1:0][31:0] u_next;

    always_comb begin
        for (int a = 0; a < 2; a++) begin
            if (!dpay_reg[DIV_STEPS].pos) begin
                u_next[a] = '0;
            end else if (dpay_reg[DIV_STEPS].ovf[a]) begin
                u_next[a] = dpay_reg[DIV_STEPS].neg[a] ? 32'h8000_0000 : 32'h7fff_ffff;
            end else if (dpay_reg[DIV_STEPS].neg[a]) begin
                u_next[a] = 32'd0 - {1'b0, dq_reg[DIV_STEPS][a]};
            end else begin
                u_next[a] = {1'b0, dq_reg[DIV_STEPS][a]};
            end
        end
        cl_next.f   = dpay_reg[DIV_STEPS].f;
        cl_next.rho = dpay_reg[DIV_STEPS].rho;
        cl_next.ux  = u_next[0];
        cl_next.uy  = u_next[1];
    end

    logic signed [63:0] pxx_reg, pyy_reg, usq_reg, usq15_reg;
    logic signed [63:0] prw_reg [0:NWGT-1];
    logic [WORD_W-1:0]  rw_reg  [0:NWGT-1];
    logic [WORD_W-1:0]  rw3_reg [0:NWGT-1];
    logic [WORD_W-1:0]  c_reg   [0:NDIR-1];
    logic [WORD_W-1:0]  c2_reg  [0:NDIR-1];
    logic signed [63:0] cp_reg  [0:NDIR-1];
    logic [WORD_W-1:0]  c3_reg  [0:NDIR-1];
    logic [WORD_W-1:0]  cc45_reg[0:NDIR-1];
    logic [WORD_W-1:0]  poly_reg[0:NDIR-1];
    logic [WORD_W-1:0]  rwd_reg [0:NDIR-1];
    logic signed [63:0] fp_reg  [0:NDIR-1];
    logic [WORD_W-1:0]  diff_reg[0:NDIR-1];
    logic signed [63:0] rp_reg  [0:NDIR-1];
    logic [WORD_W-1:0]  g_reg   [0:NDIR-1];

    logic [WORD_W-1:0]  c_next  [0:NDIR-1];
    logic [WORD_W-1:0]  cc_next [0:NDIR-1];
    logic signed [63:0] ux1, uy1;

    always_comb begin
        ux1 = sx(cl_reg[0].ux);
        uy1 = sx(cl_reg[0].uy);
        c_next[0] = '0;
        c_next[1] = cl_reg[0].ux;
        c_next[2] = cl_reg[0].uy;
        c_next[3] = sat32(-ux1);
        c_next[4] = sat32(-uy1);
        c_next[5] = sat32(ux1 + uy1);
        c_next[6] = sat32(uy1 - ux1);
        c_next[7] = sat32(-(ux1 + uy1));
        c_next[8] = sat32(ux1 - uy1);
        for (int d = 0; d < NDIR; d++) begin
            cc_next[d] = sat32(cp_reg[d] >>> FRAC_BITS);
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            cl_reg[0] <= cl_next;
            for (int s = 1; s < 9; s++) begin
                cl_reg[s] <= cl_reg[s-1];
            end
            // M1
            pxx_reg <= sx(cl_reg[0].ux) * sx(cl_reg[0].ux);
            pyy_reg <= sx(cl_reg[0].uy) * sx(cl_reg[0].uy);
            for (int w = 0; w < NWGT; w++) begin
                prw_reg[w] <= sx(cl_reg[0].rho) * $signed({39'd0, wgt_reg[w]});
            end
            for (int d = 0; d < NDIR; d++) begin
                c_reg[d] <= c_next[d];
            end
            // M2
            usq_reg <= sx(sat32(sx(sat32(pxx_reg >>> FRAC_BITS))
                                + sx(sat32(pyy_reg >>> FRAC_BITS))));
            for (int w = 0; w < NWGT; w++) begin
                rw_reg[w] <= sat32(prw_reg[w] >>> FRAC_BITS);
            end
            for (int d = 0; d < NDIR; d++) begin
                cp_reg[d] <= sx(c_reg[d]) * sx(c_reg[d]);
                c2_reg[d] <= c_reg[d];
            end
            // M3
            usq15_reg <= sx(sat32((usq_reg * 64'sd3) >>> 1));
            rw3_reg   <= rw_reg;
            for (int d = 0; d < NDIR; d++) begin
                c3_reg[d]   <= sat32(sx(c2_reg[d]) * 64'sd3);
                cc45_reg[d] <= sat32((sx(cc_next[d]) * 64'sd9) >>> 1);
            end
            // M4
            for (int d = 0; d < NDIR; d++) begin
                poly_reg[d] <= sat32(ONE + sx(c3_reg[d]) + sx(cc45_reg[d]) - usq15_reg);
                rwd_reg[d]  <= (d == 0) ? rw3_reg[0] : (d <= 4) ? rw3_reg[1] : rw3_reg[2];
            end
            // M5
            for (int d = 0; d < NDIR; d++) begin
                fp_reg[d] <= sx(rwd_reg[d]) * sx(poly_reg[d]);
            end
            // M6
            for (int d = 0; d < NDIR; d++) begin
                diff_reg[d] <= sat32(sx(cl_reg[5].f[d]) - sx(sat32(fp_reg[d] >>> FRAC_BITS)));
            end
            // M7
            for (int d = 0; d < NDIR; d++) begin
                rp_reg[d] <= $signed({38'd0, omega_reg}) * sx(diff_reg[d]);
            end
            // M8
            for (int d = 0; d < NDIR; d++) begin
                g_reg[d] <= sat32(sx(cl_reg[7].f[d]) - sx(sat32(rp_reg[d] >>> FRAC_BITS)));
            end
        end
    end

    always_comb begin
        for (int d = 0; d < NDIR; d++) begin
            m_tdata[d*WORD_W +: WORD_W] = g_reg[d];
        end
        m_tdata[9*WORD_W  +: WORD_W] = cl_reg[8].rho;
        m_tdata[10*WORD_W +: WORD_W] = cl_reg[8].ux;
        m_tdata[11*WORD_W +: WORD_W] = cl_reg[8].uy;
    end

    `D2Q9_ASSERT_IMPL(a_vel_zero, m_tvalid && ($signed(m_tdata[319:288]) <= 32'sd0), (m_tdata[383:320] == 64'd0), "velocity not zero at non-positive density")
    `D2Q9_ASSERT_IMPL(a_stall_hold, m_tvalid && !m_tready, !s_tready, "input taken while output stalled")
    `D2Q9_ASSERT_NEXT(a_reset_empty, !aresetn, !m_tvalid, "output valid right after reset")

endmodule
